FILE: rtl/core/gqsd_pkg.sv
// Package for the Gray-coded QAM slicer/demapper.
// Holds payload structs, register indexes, mode codes and field widths.
// No dependencies.
package gqsd_pkg;

   localparam int DATA_W       = 32;
   localparam int SYM_W        = 12;
   localparam int BPS_W        = 4;
   localparam int ALPHA_W      = 31;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 31;
   localparam int MAX_BITS_DEF = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE  = 2'd0,
      CSR_BPS   = 2'd1,
      CSR_ALPHA = 2'd2,
      CSR_NONE  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_ASK  = 2'd0,
      MODE_QAM  = 2'd1,
      MODE_BPSK = 2'd2,
      MODE_QPSK = 2'd3
   } mode_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sample_i;
      logic signed [DATA_W-1:0] sample_q;
   } req_type;

   typedef struct packed {
      logic        [SYM_W-1:0]  symbol;
      logic signed [DATA_W-1:0] residual_i;
      logic signed [DATA_W-1:0] residual_q;
   } rsp_type;

endpackage

FILE: rtl/core/gqsd_step.sv
// One successive-approximation slicer stage: decides at most one bit on I and one on Q, as each is active.
// Depends on gqsd_pkg.
module gqsd_step import gqsd_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF,
   parameter int STEP     = 0,
   parameter int CNT_W    = $clog2(MAX_BITS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [ALPHA_W-1:0]  alpha,
   input  logic [CNT_W-1:0]    n_i,
   input  logic [CNT_W-1:0]    n_q,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [DATA_W-1:0]   in_vi,
   input  logic [DATA_W-1:0]   in_vq,
   input  logic [MAX_BITS-1:0] in_si,
   input  logic [MAX_BITS-1:0] in_sq,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [DATA_W-1:0]   out_vi,
   output logic [DATA_W-1:0]   out_vq,
   output logic [MAX_BITS-1:0] out_si,
   output logic [MAX_BITS-1:0] out_sq
);

   logic                valid_ff;
   logic [DATA_W-1:0]   vi_ff, vi_in;
   logic [DATA_W-1:0]   vq_ff, vq_in;
   logic [MAX_BITS-1:0] si_ff, si_in;
   logic [MAX_BITS-1:0] sq_ff, sq_in;
   logic                act_i, act_q, pos_i, pos_q;
   logic [CNT_W-1:0]    k_i, k_q;
   logic [DATA_W-1:0]   ref_i, ref_q;
   logic                load;

   always_comb begin
      act_i = 32'(n_i) > STEP;
      act_q = 32'(n_q) > STEP;
      k_i   = CNT_W'(32'(n_i) - 32'(STEP) - 32'd1);
      k_q   = CNT_W'(32'(n_q) - 32'(STEP) - 32'd1);
      ref_i = {1'b0, alpha} << k_i;
      ref_q = {1'b0, alpha} << k_q;
      pos_i = (in_vi != '0) && !in_vi[DATA_W-1];
      pos_q = (in_vq != '0) && !in_vq[DATA_W-1];
      vi_in = in_vi;
      si_in = in_si;
      vq_in = in_vq;
      sq_in = in_sq;
      if (act_i) begin
         si_in = {in_si[MAX_BITS-2:0], pos_i};
         vi_in = pos_i ? in_vi - ref_i : in_vi + ref_i;
      end
      if (act_q) begin
         sq_in = {in_sq[MAX_BITS-2:0], pos_q};
         vq_in = pos_q ? in_vq - ref_q : in_vq + ref_q;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vi_ff <= vi_in;
         vq_ff <= vq_in;
         si_ff <= si_in;
         sq_ff <= sq_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vi    = vi_ff;
   assign out_vq    = vq_ff;
   assign out_si    = si_ff;
   assign out_sq    = sq_ff;

endmodule

FILE: rtl/core/gqsd_out.sv
// Output stage: Gray-encodes and packs the decided bits (sign bits in BPSK/QPSK) and holds the result.
// Depends on gqsd_pkg.
module gqsd_out import gqsd_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF,
   parameter int CNT_W    = $clog2(MAX_BITS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  mode_type            mode,
   input  logic [CNT_W-1:0]    n_q,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [DATA_W-1:0]   in_vi,
   input  logic [DATA_W-1:0]   in_vq,
   input  logic [MAX_BITS-1:0] in_si,
   input  logic [MAX_BITS-1:0] in_sq,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp
);

   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   logic [MAX_BITS-1:0] gray_i, gray_q;
   logic [DATA_W-1:0]   packed_sym;
   logic                neg_i, neg_q;

   always_comb begin
      gray_i     = in_si ^ (in_si >> 1);
      gray_q     = in_sq ^ (in_sq >> 1);
      packed_sym = (DATA_W'(gray_i) << n_q) + DATA_W'(gray_q);
      neg_i      = (in_vi == '0) || in_vi[DATA_W-1];
      neg_q      = (in_vq == '0) || in_vq[DATA_W-1];
      rsp_in.symbol     = packed_sym[SYM_W-1:0];
      rsp_in.residual_i = in_vi;
      rsp_in.residual_q = in_vq;
      case (mode)
         MODE_BPSK: begin
            rsp_in.symbol     = SYM_W'(neg_i);
            rsp_in.residual_i = '0;
            rsp_in.residual_q = '0;
         end
         MODE_QPSK: begin
            rsp_in.symbol     = SYM_W'({neg_q, neg_i});
            rsp_in.residual_i = '0;
            rsp_in.residual_q = '0;
         end
         default: begin
         end
      endcase
   end

   assign in_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_ready) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: rtl/core/gray_qam_slicer_demapper.sv
// Gray-coded ASK/QAM hard slicer and BPSK/QPSK sign demapper. One sample is
// taken per clock while req_ready is high; each result passes through
// one register stage per slicer bit and then the output register. Stages close
// bubbles, so a stalled result blocks the input only once every stage holds a
// sample. The configuration registers feed every stage directly; write them
// only while no sample is in flight. Depends on gqsd_pkg, gqsd_step and gqsd_out.
module gray_qam_slicer_demapper import gqsd_pkg::*; #(
   parameter int MAX_BITS = MAX_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BITS + 1);

   mode_type           mode_ff;
   logic [BPS_W-1:0]   bps_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [CNT_W-1:0]   m_cnt, n_i, n_q;

   logic                v   [MAX_BITS+1];
   logic                r   [MAX_BITS+1];
   logic [DATA_W-1:0]   vi  [MAX_BITS+1];
   logic [DATA_W-1:0]   vq  [MAX_BITS+1];
   logic [MAX_BITS-1:0] si  [MAX_BITS+1];
   logic [MAX_BITS-1:0] sq  [MAX_BITS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_QAM;
         bps_ff   <= BPS_W'(4);
         alpha_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:  mode_ff  <= mode_type'(csr_wdata[1:0]);
            CSR_BPS:   bps_ff   <= csr_wdata[BPS_W-1:0];
            CSR_ALPHA: alpha_ff <= csr_wdata[ALPHA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (32'(bps_ff) > MAX_BITS) begin
         m_cnt = CNT_W'(MAX_BITS);
      end else begin
         m_cnt = CNT_W'(bps_ff);
      end
      case (mode_ff)
         MODE_ASK: begin
            n_i = m_cnt;
            n_q = '0;
         end
         MODE_QAM: begin
            n_i = CNT_W'((32'(m_cnt) + 32'd1) >> 1);
            n_q = m_cnt >> 1;
         end
         default: begin
            n_i = '0;
            n_q = '0;
         end
      endcase
   end

   assign v[0]    = req_valid;
   assign req_ready = r[0];
   assign vi[0]   = req.sample_i;
   assign vq[0]   = req.sample_q;
   assign si[0]   = '0;
   assign sq[0]   = '0;

   for (genvar j = 0; j < MAX_BITS; j++) begin : g_step
      gqsd_step #(
         .MAX_BITS (MAX_BITS),
         .STEP     (j),
         .CNT_W    (CNT_W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .alpha     (alpha_ff),
         .n_i       (n_i),
         .n_q       (n_q),
         .in_valid  (v[j]),
         .in_ready  (r[j]),
         .in_vi     (vi[j]),
         .in_vq     (vq[j]),
         .in_si     (si[j]),
         .in_sq     (sq[j]),
         .out_valid (v[j+1]),
         .out_ready (r[j+1]),
         .out_vi    (vi[j+1]),
         .out_vq    (vq[j+1]),
         .out_si    (si[j+1]),
         .out_sq    (sq[j+1])
      );
   end

   gqsd_out #(
      .MAX_BITS (MAX_BITS),
      .CNT_W    (CNT_W)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .n_q       (n_q),
      .in_valid  (v[MAX_BITS]),
      .in_ready  (r[MAX_BITS]),
      .in_vi     (vi[MAX_BITS]),
      .in_vq     (vq[MAX_BITS]),
      .in_si     (si[MAX_BITS]),
      .in_sq     (sq[MAX_BITS]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   a_empty_out_takes_input: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output register");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_drain_without_feed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !v[MAX_BITS] |=> !rsp_valid)
      else $error("result appeared without an item in the last slicer stage");

endmodule

FILE: test/gray_qam_slicer_demapper_tb.sv
`timescale 1ns / 100ps
// Testbench for gray_qam_slicer_demapper: random and directed I/Q samples under
// register settings, with a scoreboard that predicts symbol and residuals in order.
// Depends on gqsd_pkg and the gray_qam_slicer_demapper RTL.
module gray_qam_slicer_demapper_tb;
   import gqsd_pkg::*;

   localparam int PIPE_LAT     = MAX_BITS_DEF + 1;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1300;

   class slicer_scoreboard;
      mode_type           mode;
      logic [BPS_W-1:0]   bps;
      logic [ALPHA_W-1:0] alpha;
      rsp_type            expected_q[$];
      int                 errors;

      function new();
         mode   = MODE_QAM;
         bps    = BPS_W'(4);
         alpha  = '0;
         errors = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_config(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MODE:  mode = mode_type'(data[1:0]);
            CSR_BPS:   bps = data[BPS_W-1:0];
            CSR_ALPHA: alpha = data[ALPHA_W-1:0];
            default: ;
         endcase
      endfunction

      function int bits_used();
         return (bps > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(bps);
      endfunction

      function bit is_positive(logic [DATA_W-1:0] v);
         return (v != '0) && !v[DATA_W-1];
      endfunction

      function logic [DATA_W-1:0] slice_gray(input logic [DATA_W-1:0] v_in, input int nbits,
                                             output logic [DATA_W-1:0] residual);
         logic [DATA_W-1:0] v;
         logic [DATA_W-1:0] s;
         logic [DATA_W-1:0] step;
         v = v_in;
         s = '0;
         for (int k = nbits - 1; k >= 0; k--) begin
            step = {1'b0, alpha} << k;
            if (is_positive(v)) begin
               s = {s[DATA_W-2:0], 1'b1};
               v = v - step;
            end else begin
               s = {s[DATA_W-2:0], 1'b0};
               v = v + step;
            end
         end
         residual = v;
         return s ^ (s >> 1);
      endfunction

      function void note_sample(req_type item);
         rsp_type           want;
         logic [DATA_W-1:0] si;
         logic [DATA_W-1:0] sq;
         logic [DATA_W-1:0] ri;
         logic [DATA_W-1:0] rq;
         logic [DATA_W-1:0] sym;
         int                m;
         m  = bits_used();
         ri = '0;
         rq = '0;
         case (mode)
            MODE_ASK: begin
               sym = slice_gray(item.sample_i, m, ri);
               rq  = item.sample_q;
            end
            MODE_QAM: begin
               si  = slice_gray(item.sample_i, (m + 1) >> 1, ri);
               sq  = slice_gray(item.sample_q, m >> 1, rq);
               sym = (si << (m >> 1)) + sq;
            end
            MODE_BPSK: sym = DATA_W'(!is_positive(item.sample_i));
            default: begin
               sym = DATA_W'({!is_positive(item.sample_q), !is_positive(item.sample_i)});
            end
         endcase
         want.symbol     = sym[SYM_W-1:0];
         want.residual_i = ri;
         want.residual_q = rq;
         expected_q.push_back(want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            if (errors < 10)
               $display("unexpected result: symbol %0h residual_i %0d residual_q %0d",
                        got.symbol, got.residual_i, got.residual_q);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.symbol !== want.symbol || got.residual_i !== want.residual_i ||
             got.residual_q !== want.residual_q) begin
            if (errors < 10) begin
               $display("mismatch: symbol exp %0h got %0h", want.symbol, got.symbol);
               $display("  residual_i exp %0d got %0d", want.residual_i, got.residual_i);
               $display("  residual_q exp %0d got %0d", want.residual_q, got.residual_q);
            end
            errors++;
         end
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req       = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   slicer_scoreboard board = new();
   int               cycle_count = 0;
   int               hold_cycles = 0;
   bit               quiet = 1'b0;

   gray_qam_slicer_demapper DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp);
   end

   initial begin : rsp_side
      int n;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [DATA_W-1:0] pick_sample(int bits);
      logic signed [DATA_W-1:0] level;
      logic [DATA_W-1:0]        noise;
      noise = $urandom() >> $urandom_range(1, 31);
      if ($urandom_range(0, 1) == 1)
         noise = -noise;
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return DATA_W'(1);
               2: return '1;
               3: return 32'h7FFF_FFFF;
               default: return 32'h8000_0000;
            endcase
         end
         2: return noise;
         default: begin
            if (bits == 0)
               return $urandom();
            level = 2 * $urandom_range(0, (1 << bits) - 1) + 1 - (1 << bits);
            return level * {1'b0, board.alpha} + noise;
         end
      endcase
   endfunction

   // one transfer on the sample channel; returns at the falling edge after it
   task automatic send_sample(input logic [DATA_W-1:0] si, input logic [DATA_W-1:0] sq);
      req_type item;
      item.sample_i = si;
      item.sample_q = sq;
      req       <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_sample(item);
      @(negedge clock);
   endtask

   task automatic pause_req(input int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // drop valid, wait for every outstanding result, then let the pipe empty
   task automatic settle(input int tail);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.note_config(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] w_mode,
                            input logic [CSR_DATA_W-1:0] w_bps,
                            input logic [CSR_DATA_W-1:0] w_alpha);
      settle(PIPE_LAT + 4);
      csr_write(CSR_MODE, w_mode);
      csr_write(CSR_BPS, w_bps);
      csr_write(CSR_ALPHA, w_alpha);
   endtask

   task automatic random_config();
      logic [CSR_DATA_W-1:0] w_mode;
      logic [CSR_DATA_W-1:0] w_bps;
      logic [CSR_DATA_W-1:0] w_alpha;
      w_mode      = ($urandom_range(0, 1) == 1) ? CSR_DATA_W'($urandom()) : '0;
      w_mode[1:0] = 2'($urandom_range(0, 3));
      w_bps       = ($urandom_range(0, 1) == 1) ? CSR_DATA_W'($urandom()) : '0;
      w_bps[BPS_W-1:0] = BPS_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(1, 12));
      case ($urandom_range(0, 5))
         0: w_alpha = CSR_DATA_W'($urandom());
         1: w_alpha = ($urandom_range(0, 1) == 1) ? '1 : '0;
         2: w_alpha = CSR_DATA_W'($urandom()) >> $urandom_range(0, 30);
         default: begin
            w_alpha = CSR_DATA_W'(32'h4000_0000 >> $urandom_range(0, 11)) +
                      CSR_DATA_W'($urandom_range(0, 255));
         end
      endcase
      configure(w_mode, w_bps, w_alpha);
      if ($urandom_range(0, 7) == 0)
         csr_write(CSR_NONE, CSR_DATA_W'($urandom()));
   endtask

   initial begin : stimulus
      int sent;
      int n;
      int phase;
      int m;
      int ib;
      int qb;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_sample('0, '0);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);

      configure(CSR_DATA_W'(MODE_ASK) | 31'h7FFF_FFFC, CSR_DATA_W'(15), 31'h7FFF_FFFF);
      csr_write(CSR_NONE, '1);
      send_sample(DATA_W'(1), '1);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF);

      configure(CSR_DATA_W'(MODE_QAM), CSR_DATA_W'(1), 31'h4000_0000);
      send_sample(32'h2000_0000, DATA_W'(12345));
      send_sample(-DATA_W'(5), '0);

      configure(CSR_DATA_W'(MODE_ASK), '0, 31'h1234_5678);
      send_sample(DATA_W'(123), -DATA_W'(456));
      configure(CSR_DATA_W'(MODE_QAM), 31'h7FFF_FFF0, 31'h0000_0100);
      send_sample(-DATA_W'(7), DATA_W'(7));

      configure(CSR_DATA_W'(MODE_BPSK), CSR_DATA_W'(4), 31'h100);
      send_sample('0, '0);
      send_sample(DATA_W'(1), '1);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF);

      configure(CSR_DATA_W'(MODE_QPSK), CSR_DATA_W'(4), 31'h100);
      send_sample('0, '0);
      send_sample(DATA_W'(1), '1);
      send_sample('1, DATA_W'(1));
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);

      configure(CSR_DATA_W'(MODE_QAM), CSR_DATA_W'(12), 31'h0010_0000);
      repeat (3) send_sample(pick_sample(6), pick_sample(6));

      configure(CSR_DATA_W'(MODE_ASK), CSR_DATA_W'(12), CSR_DATA_W'(1));
      send_sample(pick_sample(12), $urandom());
      send_sample('1, '0);

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = (sent >= RANDOM_ITEMS - 150);
         if (!quiet)
            random_config();
         m = board.bits_used();
         case (board.mode)
            MODE_ASK: begin
               ib = m;
               qb = 0;
            end
            MODE_QAM: begin
               ib = (m + 1) >> 1;
               qb = m >> 1;
            end
            default: begin
               ib = 0;
               qb = 0;
            end
         endcase
         n = $urandom_range(30, 80);
         if (phase == 3) begin
            n = 60;
            hold_cycles = 150;
         end
         for (int j = 0; j < n; j++) begin
            send_sample(pick_sample(ib), pick_sample(qb));
            sent++;
            if (phase == 5 && j == n / 2)
               settle(0);
            else if (!quiet && phase != 3 && $urandom_range(0, 7) == 0)
               pause_req($urandom_range(1, 13));
         end
         phase++;
      end

      settle(PIPE_LAT + 4);
      if (board.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
